// ===== hdl/multi_period_frequency_counter_assert.svh =====
// assertion macros for the multi-period frequency counter
// included by the rtl files that carry concurrent assertions; no other dependencies
`ifndef MULTI_PERIOD_FREQUENCY_COUNTER_ASSERT_SVH
`define MULTI_PERIOD_FREQUENCY_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MPFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MPFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MPFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MPFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/mpfc_pkg.sv =====
// shared types and constants of the multi-period frequency counter
// no dependencies; used by the divider and the top level
package mpfc_pkg;

    // field and register widths
    localparam int EDGE_W           = 16;
    localparam int TB_W             = 28;
    localparam int MILLI_W          = 10;
    localparam int PROD_W           = TB_W + EDGE_W;
    localparam int NUM_W            = PROD_W + MILLI_W;
    localparam int ELAPSED_BITS_DEF = 32;
    localparam int RES_W            = 32;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    // constants
    localparam logic [MILLI_W-1:0] MILLI       = 10'd1000;
    localparam logic [EDGE_W-1:0]  EDGES_RESET = 16'd50;
    localparam logic [TB_W-1:0]    TB_RESET    = 28'd1000000;

    // register index codes
    localparam logic REG_EDGES = 1'b0;
    localparam logic REG_TB    = 1'b1;

    // measurement phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PENDING = 2'd1;
    localparam logic [1:0] PH_RUNNING = 2'd2;

    // input transaction
    typedef struct packed {
        logic tick;
        logic edge_req;
        logic start_req;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic [1:0]       phase;
        logic             done_res;
        logic [RES_W-1:0] elapsed_result;
        logic [RES_W-1:0] freq_millihz;
        logic             elapsed_saturated;
    } t_out_item;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== hdl/mpfc_divider.sv =====
// restoring radix-2 divider, one quotient bit per cycle
// depends on mpfc_pkg for the status struct and default widths
module mpfc_divider #(
    parameter int NUM_W = mpfc_pkg::NUM_W,
    parameter int DEN_W = mpfc_pkg::ELAPSED_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output mpfc_pkg::t_div_status o_status,
    output logic [NUM_W-1:0]      o_quot
);
    import mpfc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_quot;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_quot[NUM_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_den};
        if (!trial[DEN_W+1]) begin
            n_rem  = trial[DEN_W-1:0];
            n_quot = {r_quot[NUM_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh[DEN_W-1:0];
            n_quot = {r_quot[NUM_W-2:0], 1'b0};
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

// ===== hdl/multi_period_frequency_counter.sv =====
// multi-period frequency counter: one result transaction per input transaction.
// an item that does not end a measurement gives its result in the cycle after acceptance.
// an item that ends a measurement passes two multiply steps, then the bit-serial
// divider, then the output write; no input is taken meanwhile. synchronous
// active-low reset clears control and measurement state and loads register defaults.
// depends on mpfc_pkg, mpfc_divider and multi_period_frequency_counter_assert.svh
`include "multi_period_frequency_counter_assert.svh"
module multi_period_frequency_counter #(
    parameter int ELAPSED_BITS = mpfc_pkg::ELAPSED_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mpfc_pkg::t_in_item            i_in_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mpfc_pkg::t_out_item           o_out_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mpfc_pkg::APB_AW-1:0]   paddr,
    input  logic [mpfc_pkg::APB_DW-1:0]   pwdata,
    output logic [mpfc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mpfc_pkg::*;

    localparam int EXT_W = (ELAPSED_BITS > RES_W) ? ELAPSED_BITS : RES_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_SCALE = 4'b0100,
        S_DIV   = 4'b1000
    } t_state;

    t_state                  r_state;
    logic [EDGE_W-1:0]       r_edges_cfg;
    logic [TB_W-1:0]         r_tb_hz;
    logic [1:0]              r_phase;
    logic [EDGE_W-1:0]       r_edge_count;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic                    r_sat;
    logic [RES_W-1:0]        r_last_elapsed;
    logic [RES_W-1:0]        r_last_freq;
    logic                    r_last_sat;
    logic [1:0]              r_hold_phase;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic [1:0]              n_phase;
    logic [EDGE_W-1:0]       n_edge_count;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic                    n_sat;
    logic                    n_out_valid;
    logic                    fin;
    logic [EDGE_W:0]         edge_next;
    logic [EDGE_W:0]         edge_target;
    logic [EDGE_W-1:0]       edges_eff;
    logic                    in_accept;
    logic                    out_take;
    logic                    cfg_wr;

    t_div_status             div_st;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [NUM_W-1:0]        div_quot;

    logic [EXT_W-1:0]        elapsed_ext;
    logic                    over32;
    logic [RES_W-1:0]        fin_elapsed;
    logic [RES_W-1:0]        fin_freq;
    logic                    fin_sat;

    // handshakes
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_EDGES: prdata = APB_DW'(r_edges_cfg);
            REG_TB:    prdata = APB_DW'(r_tb_hz);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges_cfg <= EDGES_RESET;
            r_tb_hz     <= TB_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_EDGES: r_edges_cfg <= pwdata[EDGE_W-1:0];
                REG_TB:    r_tb_hz     <= pwdata[TB_W-1:0];
                default:   ;
            endcase
        end
    end

    // zero edge setting counts as one
    assign edges_eff = (r_edges_cfg == '0) ? EDGE_W'(1) : r_edges_cfg;

    // per-transaction phase update: tick, then edge, then start
    always_comb begin
        n_phase      = r_phase;
        n_edge_count = r_edge_count;
        n_elapsed    = r_elapsed;
        n_sat        = r_sat;
        fin          = 1'b0;
        edge_next    = {1'b0, r_edge_count} + 1'b1;
        edge_target  = {1'b0, edges_eff};
        if (i_in_data.tick && r_phase == PH_RUNNING) begin
            if (r_elapsed == '1) begin
                n_sat = 1'b1;
            end else begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end
        if (i_in_data.edge_req) begin
            if (r_phase == PH_PENDING) begin
                n_elapsed    = '0;
                n_edge_count = '0;
                n_sat        = 1'b0;
                n_phase      = PH_RUNNING;
            end else if (r_phase == PH_RUNNING) begin
                if (edge_next >= edge_target) begin
                    fin     = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_edge_count = edge_next[EDGE_W-1:0];
                end
            end
        end
        if (n_phase != PH_PENDING && n_phase != PH_RUNNING) begin
            n_phase = PH_IDLE;
        end
        if (i_in_data.start_req) begin
            n_phase = PH_PENDING;
        end
    end

    // output slot: cleared when taken, set when a result is written
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if ((r_state == S_IDLE && in_accept && !fin) || (r_state == S_DIV && div_st.done)) begin
            n_out_valid = 1'b1;
        end
    end

    // divider: numerator scaled to millihertz, divisor is the tick count
    assign div_start = (r_state == S_SCALE);
    assign div_num   = NUM_W'(r_prod) * NUM_W'(MILLI);

    mpfc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (ELAPSED_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (div_num),
        .i_den    (r_elapsed),
        .o_status (div_st),
        .o_quot   (div_quot)
    );

    // result saturation
    always_comb begin
        elapsed_ext = EXT_W'(r_elapsed);
        over32      = (elapsed_ext > EXT_W'({RES_W{1'b1}}));
        fin_elapsed = over32 ? '1 : elapsed_ext[RES_W-1:0];
        fin_sat     = r_sat || over32;
        if (r_elapsed == '0 || (|div_quot[NUM_W-1:RES_W])) begin
            fin_freq = '1;
        end else begin
            fin_freq = div_quot[RES_W-1:0];
        end
    end

    // sequencer and measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_IDLE;
            r_edge_count   <= '0;
            r_elapsed      <= '0;
            r_sat          <= 1'b0;
            r_last_elapsed <= '0;
            r_last_freq    <= '0;
            r_last_sat     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_phase      <= n_phase;
                        r_edge_count <= n_edge_count;
                        r_elapsed    <= n_elapsed;
                        r_sat        <= n_sat;
                        if (fin) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_st.done) begin
                        r_last_elapsed <= fin_elapsed;
                        r_last_freq    <= fin_freq;
                        r_last_sat     <= fin_sat;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_accept) begin
            r_hold_phase <= n_phase;
            if (!fin) begin
                r_out_data.phase             <= n_phase;
                r_out_data.done_res          <= 1'b0;
                r_out_data.elapsed_result    <= r_last_elapsed;
                r_out_data.freq_millihz      <= r_last_freq;
                r_out_data.elapsed_saturated <= r_last_sat;
            end
        end else if (r_state == S_DIV && div_st.done) begin
            r_out_data.phase             <= r_hold_phase;
            r_out_data.done_res          <= 1'b1;
            r_out_data.elapsed_result    <= fin_elapsed;
            r_out_data.freq_millihz      <= fin_freq;
            r_out_data.elapsed_saturated <= fin_sat;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_tb_hz) * PROD_W'(edges_eff);
        end
    end

    // checks
    `MPFC_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall,
                     "busy but not stalled")
    `MPFC_ASSERT_NXT(a_fin_starts, i_clk, i_rst_n, in_accept && fin, r_state == S_MUL,
                     "finish not started")
    `MPFC_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, div_st.done, r_state == S_DIV,
                     "stray divider done")
    `MPFC_ASSERT_IMP(a_full_stalls, i_clk, i_rst_n, r_out_valid && i_out_stall, o_in_stall,
                     "input taken over full output")
    `MPFC_ASSERT_NXT(a_done_out, i_clk, i_rst_n, r_state == S_DIV && div_st.done,
                     r_out_valid && r_out_data.done_res, "done result missing")

endmodule
